// ----- src/slfr_pkg.sv -----
// Package for the stuffed-length frame receiver: sizes, codes and shared types.
// Depends on nothing; every other file of the block imports it.
package slfr_pkg;

	localparam int FRAME_BUFFER_DEPTH = 256;
	localparam int STORE_AW = $clog2(FRAME_BUFFER_DEPTH);
	localparam int LEN_W = 9;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [1:0] REG_START_BYTE = 2'd0;
	localparam logic [1:0] REG_EXT_MARKER = 2'd1;
	localparam logic [1:0] REG_TWO_BYTE_EN = 2'd2;

	localparam logic [7:0] START_BYTE_RST = 8'd26;
	localparam logic [7:0] EXT_MARKER_RST = 8'd255;

	typedef enum logic [1:0] {
		ACT_RECV    = 2'd0,
		ACT_READ    = 2'd1,
		ACT_RELEASE = 2'd2,
		ACT_NOP     = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		PH_LEN0   = 3'd0,
		PH_LEN_LO = 3'd1,
		PH_LEN_HI = 3'd2,
		PH_DATA   = 3'd3,
		PH_ERR    = 3'd4,
		PH_DONE   = 3'd5
	} phase_t;

	typedef struct packed {
		logic [7:0] start_byte;
		logic [7:0] ext_marker;
		logic       two_byte_en;
	} cfg_t;

	typedef struct packed {
		logic                en;
		logic [STORE_AW-1:0] addr;
		logic [7:0]          data;
	} wr_req_t;

	typedef struct packed {
		logic             frame_ready;
		logic [LEN_W-1:0] frame_length;
		phase_t           phase;
		logic             dropped;
	} result_t;

endpackage

// ----- src/slfr_cfg.sv -----
// Configuration register bank behind an APB-style port.
// Depends on slfr_pkg for register indexes, reset values and the cfg_t type.
module slfr_cfg
	import slfr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte  <= START_BYTE_RST;
			cfg_q.ext_marker  <= EXT_MARKER_RST;
			cfg_q.two_byte_en <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_START_BYTE:  cfg_q.start_byte  <= pwdata[7:0];
				REG_EXT_MARKER:  cfg_q.ext_marker  <= pwdata[7:0];
				REG_TWO_BYTE_EN: cfg_q.two_byte_en <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_START_BYTE:  prdata = PDATA_W'(cfg_q.start_byte);
			REG_EXT_MARKER:  prdata = PDATA_W'(cfg_q.ext_marker);
			REG_TWO_BYTE_EN: prdata = PDATA_W'(cfg_q.two_byte_en);
			default:         prdata = '0;
		endcase
	end

endmodule

// ----- src/slfr_ctrl.sv -----
// Receive control: byte unstuffing, length decoding, frame hold and release.
// Depends on slfr_pkg; drives the frame store write port and the per-item result.
module slfr_ctrl
	import slfr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       accept,
	input  action_t    action,
	input  logic [7:0] rx_byte,
	output wr_req_t    wr_req,
	output result_t    result
);

	phase_t           phase_q, phase_d, ph_eff;
	logic             start_seen_q, start_seen_d;
	logic [LEN_W-1:0] exp_len_q, exp_len_d;
	logic [LEN_W-1:0] wr_pos_q, wr_pos_d, wr_pos_eff, wr_pos_inc;
	logic [LEN_W-1:0] held_q, held_d;
	logic             do_take, opens, dropped;
	logic [LEN_W-1:0] short_len;
	logic [15:0]      long_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_LEN0;
			start_seen_q <= 1'b0;
			exp_len_q    <= '0;
			wr_pos_q     <= '0;
			held_q       <= '0;
		end else begin
			phase_q      <= phase_d;
			start_seen_q <= start_seen_d;
			exp_len_q    <= exp_len_d;
			wr_pos_q     <= wr_pos_d;
			held_q       <= held_d;
		end
	end

	// A one-byte length skips the start value itself.
	assign short_len  = (rx_byte > cfg.start_byte) ? LEN_W'(rx_byte - 8'd1) : LEN_W'(rx_byte);
	assign long_len   = {rx_byte, exp_len_q[7:0]};
	assign wr_pos_inc = wr_pos_eff + LEN_W'(1);

	always_comb begin
		do_take      = 1'b0;
		opens        = 1'b0;
		dropped      = 1'b0;
		start_seen_d = start_seen_q;
		held_d       = held_q;
		if (accept) begin
			unique case (action)
				ACT_RECV: begin
					if (held_q != '0) begin
						dropped = 1'b1;
					end else if (start_seen_q) begin
						do_take      = 1'b1;
						opens        = (rx_byte != cfg.start_byte);
						start_seen_d = 1'b0;
					end else if (rx_byte == cfg.start_byte) begin
						start_seen_d = 1'b1;
					end else begin
						do_take = 1'b1;
					end
				end
				ACT_RELEASE: held_d = '0;
				ACT_READ, ACT_NOP: ;
				default: ;
			endcase
		end

		ph_eff     = opens ? PH_LEN0 : phase_q;
		wr_pos_eff = opens ? '0 : wr_pos_q;
		phase_d    = phase_q;
		exp_len_d  = exp_len_q;
		wr_pos_d   = wr_pos_q;
		wr_req     = '0;
		if (do_take) begin
			phase_d  = ph_eff;
			wr_pos_d = wr_pos_eff;
			unique case (ph_eff)
				PH_LEN0: begin
					if (cfg.two_byte_en && rx_byte == cfg.ext_marker) begin
						phase_d = PH_LEN_LO;
					end else begin
						exp_len_d = short_len;
						wr_pos_d  = '0;
						phase_d   = (short_len == '0) ? PH_ERR : PH_DATA;
					end
				end
				PH_LEN_LO: begin
					exp_len_d = LEN_W'(rx_byte);
					phase_d   = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					// Only lengths up to the store depth survive the check.
					exp_len_d = LEN_W'(long_len);
					wr_pos_d  = '0;
					phase_d   = (long_len == 16'd0 || 32'(long_len) > FRAME_BUFFER_DEPTH)
						? PH_ERR : PH_DATA;
				end
				PH_DATA: begin
					wr_req.en   = (32'(wr_pos_eff) < FRAME_BUFFER_DEPTH);
					wr_req.addr = STORE_AW'(wr_pos_eff);
					wr_req.data = rx_byte;
					wr_pos_d    = wr_pos_inc;
					if (wr_pos_inc == exp_len_q) begin
						held_d  = wr_pos_inc;
						phase_d = PH_DONE;
					end
				end
				default: ;
			endcase
		end

		result.frame_ready  = (held_d != '0);
		result.frame_length = held_d;
		result.phase        = phase_d;
		result.dropped      = dropped;
	end

endmodule

// ----- src/slfr_store.sv -----
// Frame payload store: one write port, one registered read port.
// Depends on slfr_pkg for the store depth and the write request type.
module slfr_store
	import slfr_pkg::*;
(
	input  logic                clk,
	input  wr_req_t             wr_req,
	input  logic                rd_en,
	input  logic [STORE_AW-1:0] rd_addr,
	output logic [7:0]          rd_data
);

	logic [7:0] mem [FRAME_BUFFER_DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_req.en) begin
			mem[wr_req.addr] <= wr_req.data;
		end
	end

	// The read register holds its value until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- src/stuffed_length_frame_receiver_core.sv -----
// Top level of the stuffed-length frame receiver.
// Depends on slfr_pkg, slfr_cfg, slfr_ctrl and slfr_store.
//
// Usage: every input transfer carries an action: receive one line byte, read one
// stored payload byte by index, or release the held frame. Every input transfer
// yields exactly one output transfer carrying frame_ready, frame_length, read_data,
// receive_phase and byte_dropped, in input order.
// Both channels use valid and stall; a transfer happens at a clock edge where
// valid is high and stall is low. Configuration is written through the APB-style
// port (start byte at 0x0, extended length marker at 0x4, two-byte length enable
// at 0x8) while the block is idle; pready is always high.
// A result passes through the read stage and then the output register. One item is
// accepted per cycle while in_stall is low; the store is read at the accepting
// edge, and its registered read data joins the result in the output register.
// The result path has two registers (a read stage and an output register), so one
// new item is still taken while a result waits; once both hold items and the
// receiver stalls, in_stall rises until the output register drains. Reset clears
// the control state and restores the register defaults; the payload store is not
// cleared; the user must read a stored byte only after it is written (unchecked).
module stuffed_length_frame_receiver_core
	import slfr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic [7:0]         rx_byte,
	input  logic [7:0]         read_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               frame_ready,
	output logic [8:0]         frame_length,
	output logic [7:0]         read_data,
	output logic [2:0]         receive_phase,
	output logic               byte_dropped
);

	cfg_t       cfg;
	wr_req_t    wr_req;
	result_t    result;
	action_t    act;
	logic       accept;
	logic       is_read;
	logic [7:0] store_rd_data;

	// Read stage: control results plus a flag telling whether store data applies.
	logic       valid_s1;
	result_t    result_s1;
	logic       use_rd_s1;
	logic       s1_advance;

	// Output register.
	logic       out_valid_q;
	result_t    result_q;
	logic [7:0] read_data_q;

	assign act        = action_t'(action);
	assign s1_advance = !out_valid_q || !out_stall;
	assign in_stall   = valid_s1 && !s1_advance;
	assign accept     = in_valid && !in_stall;
	assign is_read    = (act == ACT_READ);

	slfr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	slfr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.accept  (accept),
		.action  (act),
		.rx_byte (rx_byte),
		.wr_req  (wr_req),
		.result  (result)
	);

	slfr_store u_store (
		.clk     (clk),
		.wr_req  (wr_req),
		.rd_en   (accept && is_read),
		.rd_addr (STORE_AW'(read_index)),
		.rd_data (store_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_s1 <= result;
			use_rd_s1 <= is_read && (32'(read_index) < FRAME_BUFFER_DEPTH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance && valid_s1) begin
			result_q    <= result_s1;
			read_data_q <= use_rd_s1 ? store_rd_data : 8'd0;
		end
	end

	assign out_valid     = out_valid_q;
	assign frame_ready   = result_q.frame_ready;
	assign frame_length  = result_q.frame_length;
	assign read_data     = read_data_q;
	assign receive_phase = result_q.phase;
	assign byte_dropped  = result_q.dropped;

endmodule

// ----- src/slfr_checker.sv -----
// Port-level checks for the stuffed-length frame receiver, bound to its top level.
// Depends on slfr_pkg for the phase codes and the store depth.
module slfr_checker
	import slfr_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       frame_ready,
	input logic [8:0] frame_length,
	input logic [7:0] read_data,
	input logic [2:0] receive_phase,
	input logic       byte_dropped
);

	// A stalled result stays and does not change.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(frame_length)
			&& $stable(read_data) && $stable(receive_phase))
		else $error("stalled result changed");

	a_ready_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> frame_ready == (frame_length != 9'd0))
		else $error("frame_ready disagrees with frame_length");

	// A frame is only held while the receiver sits in the complete phase.
	a_held_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_ready |-> receive_phase == PH_DONE)
		else $error("frame held outside complete phase");

	// A dropped byte implies a frame still held afterwards.
	a_drop_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_dropped |-> frame_ready)
		else $error("byte dropped with no frame held");

	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(frame_length) <= FRAME_BUFFER_DEPTH)
		else $error("frame_length exceeds store depth");

endmodule

bind stuffed_length_frame_receiver_core slfr_checker u_slfr_checker (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for stuffed_length_frame_receiver_core, with no other files.
// Uses slfr_pkg for the action, phase and register codes; everything else is local.
module tb;
	import slfr_pkg::*;

	// The run is stopped by force if it ever gets this far.
	localparam int CYCLE_LIMIT = 400000;

	// One input transfer, together with the idle cycles that come before it and
	// a flag that holds it back until every earlier result has been checked.
	typedef struct {
		action_t     act;
		logic [7:0]  rx;
		logic [7:0]  idx;
		int unsigned gap;
		bit          drain;
	} rx_item_t;

	// Expected contents of one output transfer.
	typedef struct packed {
		logic       ready;
		logic [8:0] length;
		logic [7:0] rdata;
		phase_t     phase;
		logic       dropped;
	} rx_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         action = ACT_NOP;
	logic [7:0]         rx_byte = 8'h00;
	logic [7:0]         read_index = 8'h00;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               frame_ready;
	logic [8:0]         frame_length;
	logic [7:0]         read_data;
	logic [2:0]         receive_phase;
	logic               byte_dropped;

	stuffed_length_frame_receiver_core i_dut (.*);

	// Stimulus waiting to be sent and results waiting to be checked.
	rx_item_t   pending_items[$];
	rx_result_t expected_results[$];
	rx_item_t   cur_item;

	// The driver owns the accepted count; the monitor updates its count with a
	// nonblocking write, so the driver always sees the value from before the edge.
	int accepted = 0;
	int results_seen = 0;
	int mismatches = 0;
	int n_pushed = 0;
	int cycles = 0;
	int unsigned gap_count = 0;
	int unsigned stall_left = 0;
	int unsigned gap_max = 0;
	int unsigned stall_max = 0;
	bit force_pause = 1'b0;

	// Register copies, updated at the edge where the write lands in the block.
	logic [7:0] cfg_start = START_BYTE_RST;
	logic [7:0] cfg_marker = EXT_MARKER_RST;
	logic       cfg_two_byte = 1'b0;

	// Receiver state as the predictor sees it.
	phase_t      rx_phase = PH_LEN0;
	logic        esc_seen = 1'b0;
	logic [15:0] want_len = '0;
	logic [8:0]  wr_pos = '0;
	logic [8:0]  held_len = '0;
	logic [7:0]  payload_store [FRAME_BUFFER_DEPTH];

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	//----------------------------------------------------------------------
	// Predictor
	//----------------------------------------------------------------------

	// A length of zero or one beyond the store puts the receiver in its error phase.
	function automatic phase_t length_phase(logic [15:0] len);
		return (len == 16'd0 || len > 16'(FRAME_BUFFER_DEPTH)) ? PH_ERR : PH_DATA;
	endfunction

	// One byte after unstuffing. When opens is set the byte follows a lone start
	// byte, so the frame restarts and this byte is its length byte.
	function automatic void accept_byte(logic [7:0] b, bit opens);
		logic [15:0] len;
		if (opens) begin
			wr_pos = '0;
			rx_phase = PH_LEN0;
		end
		case (rx_phase)
			PH_LEN0: begin
				if (cfg_two_byte && b == cfg_marker) begin
					rx_phase = PH_LEN_LO;
				end else begin
					// One-byte lengths skip the start value itself.
					len = (b > cfg_start) ? 16'(b) - 16'd1 : 16'(b);
					want_len = len;
					wr_pos = '0;
					rx_phase = length_phase(len);
				end
			end
			PH_LEN_LO: begin
				want_len = {8'h00, b};
				rx_phase = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				len = {b, want_len[7:0]};
				want_len = len;
				wr_pos = '0;
				rx_phase = length_phase(len);
			end
			PH_DATA: begin
				if (wr_pos < 9'(FRAME_BUFFER_DEPTH))
					payload_store[wr_pos[7:0]] = b;
				wr_pos = wr_pos + 9'd1;
				if (16'(wr_pos) == want_len) begin
					held_len = wr_pos;
					rx_phase = PH_DONE;
				end
			end
			default: ;
		endcase
	endfunction

	// Advances the predicted state by one accepted transfer and returns the
	// result that the block must produce for it.
	function automatic rx_result_t predict_result(rx_item_t it);
		rx_result_t r;
		r = '0;
		case (it.act)
			ACT_RECV: begin
				if (held_len != 9'd0) begin
					r.dropped = 1'b1;
				end else if (esc_seen) begin
					// A doubled start byte is a literal; anything else opens a frame.
					accept_byte(it.rx, it.rx != cfg_start);
					esc_seen = 1'b0;
				end else if (it.rx == cfg_start) begin
					esc_seen = 1'b1;
				end else begin
					accept_byte(it.rx, 1'b0);
				end
			end
			ACT_READ: r.rdata = payload_store[it.idx];
			ACT_RELEASE: held_len = '0;
			default: ;
		endcase
		r.ready = held_len != 9'd0;
		r.length = held_len;
		r.phase = rx_phase;
		return r;
	endfunction

	//----------------------------------------------------------------------
	// Driver: one transfer at a time from pending_items
	//----------------------------------------------------------------------
	always @(posedge clk) begin
		bit loaded;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_count = 0;
		end else begin
			loaded = in_valid;
			if (in_valid && !in_stall) begin
				expected_results.push_back(predict_result(cur_item));
				accepted++;
				loaded = 1'b0;
			end
			// The next item is loaded in the same step that the last one left, so
			// valid stays high across back-to-back transfers.
			if (!loaded && pending_items.size() != 0) begin
				if (gap_count < pending_items[0].gap) begin
					gap_count++;
				end else if (!pending_items[0].drain || accepted == results_seen) begin
					cur_item = pending_items.pop_front();
					gap_count = 0;
					action <= cur_item.act;
					rx_byte <= cur_item.rx;
					read_index <= cur_item.idx;
					loaded = 1'b1;
				end
			end
			in_valid <= loaded;
		end
	end

	//----------------------------------------------------------------------
	// Monitor: checks each output transfer and stalls at random
	//----------------------------------------------------------------------
	task automatic report_mismatch(string what, int got, int want);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch at result %0d: %s is %0d, expected %0d",
				results_seen, what, got, want);
	endtask

	always @(posedge clk) begin
		rx_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen <= results_seen + 1;
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing outstanding", 1, 0);
				end else begin
					want = expected_results.pop_front();
					if (frame_ready !== want.ready)
						report_mismatch("frame_ready", frame_ready, want.ready);
					if (frame_length !== want.length)
						report_mismatch("frame_length", frame_length, want.length);
					if (read_data !== want.rdata)
						report_mismatch("read_data", read_data, want.rdata);
					if (receive_phase !== want.phase)
						report_mismatch("receive_phase", receive_phase, want.phase);
					if (byte_dropped !== want.dropped)
						report_mismatch("byte_dropped", byte_dropped, want.dropped);
				end
				stall_left = $urandom_range(0, stall_max);
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	//----------------------------------------------------------------------
	// Stimulus helpers
	//----------------------------------------------------------------------

	// Unused fields get random values so that the block is seen to ignore them.
	task automatic push_item(action_t act, logic [7:0] rx, logic [7:0] idx);
		rx_item_t it;
		it.act = act;
		it.rx = rx;
		it.idx = idx;
		it.gap = $urandom_range(0, gap_max);
		it.drain = ($urandom_range(0, 49) == 0) || force_pause;
		force_pause = 1'b0;
		pending_items.push_back(it);
		n_pushed++;
	endtask

	task automatic push_recv(logic [7:0] b);
		push_item(ACT_RECV, b, 8'($urandom));
	endtask

	task automatic push_read(logic [7:0] idx);
		push_item(ACT_READ, 8'($urandom), idx);
	endtask

	task automatic push_release();
		push_item(ACT_RELEASE, 8'($urandom), 8'($urandom));
	endtask

	// A byte inside a frame: the start value goes out doubled.
	task automatic push_data(logic [7:0] b);
		push_recv(b);
		if (b == cfg_start)
			push_recv(b);
	endtask

	// The two-byte length is only usable when its marker cannot be confused
	// with the start byte.
	function automatic bit ext_usable();
		return cfg_two_byte && cfg_marker != cfg_start;
	endfunction

	// Opens a frame of count payload bytes and sends the first keep of them.
	// Lengths that one byte cannot carry use the two-byte form, or are clipped.
	task automatic send_frame(int unsigned count, int unsigned keep);
		logic [15:0] len;
		logic [7:0]  code;
		bit          can_ext;
		bit          use_ext;
		can_ext = ext_usable();
		len = 16'(count);
		if (!can_ext && len > 16'd254)
			len = 16'd254;
		code = (len < 16'(cfg_start)) ? len[7:0] : 8'(len + 16'd1);
		use_ext = can_ext && (len > 16'd254 || code == cfg_marker ||
			$urandom_range(0, 3) == 0);
		push_recv(cfg_start);
		if (use_ext) begin
			push_recv(cfg_marker);
			push_data(len[7:0]);
			push_data(len[15:8]);
		end else begin
			push_recv(code);
		end
		for (int i = 0; i < keep && i < len; i++)
			push_data(($urandom_range(0, 5) == 0) ? cfg_start : 8'($urandom));
	endtask

	// Mostly well-formed frames with random content and size, followed by reads
	// and a release; the rest is noise, bad lengths and frames cut short.
	task automatic run_mix(int target);
		int first;
		int kind;
		int unsigned len;
		logic [15:0] bad_len;
		first = n_pushed;
		while (n_pushed - first < target) begin
			kind = $urandom_range(0, 9);
			if (kind <= 5) begin
				len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 256)
					: $urandom_range(1, 12);
				send_frame(len, len);
				repeat ($urandom_range(0, 3)) push_read(8'($urandom));
				if ($urandom_range(0, 4) == 0)
					repeat ($urandom_range(1, 3)) push_recv(8'($urandom));
				if ($urandom_range(0, 7) != 0)
					push_release();
			end else if (kind <= 7) begin
				// Loose transfers of every action; start bytes are frequent so that
				// doubled and dangling start bytes turn up in every phase.
				repeat ($urandom_range(1, 6))
					push_item(action_t'($urandom_range(0, 3)),
						($urandom_range(0, 3) == 0) ? cfg_start : 8'($urandom),
						8'($urandom));
			end else if (kind == 8) begin
				push_recv(cfg_start);
				if (ext_usable() && (cfg_start == 8'h00 || $urandom_range(0, 1) == 1)) begin
					push_recv(cfg_marker);
					bad_len = ($urandom_range(0, 1) == 1) ? 16'd0
						: 16'($urandom_range(FRAME_BUFFER_DEPTH + 1, 65535));
					push_data(bad_len[7:0]);
					push_data(bad_len[15:8]);
				end else if (cfg_start != 8'h00) begin
					push_recv(8'h00);
				end
				repeat ($urandom_range(0, 3)) push_recv(8'($urandom));
			end else begin
				// A frame cut off by the next opening start byte.
				len = $urandom_range(5, 20);
				send_frame(len, $urandom_range(1, len - 1));
			end
		end
	endtask

	// APB write: setup cycle, then access cycle; the register takes the value
	// at the edge that ends the access cycle.
	task automatic write_reg(logic [1:0] idx, logic [PDATA_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_START_BYTE: cfg_start = val[7:0];
			REG_EXT_MARKER: cfg_marker = val[7:0];
			REG_TWO_BYTE_EN: cfg_two_byte = val[0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(logic [7:0] sb, logic [7:0] mk, logic en);
		write_reg(REG_START_BYTE, PDATA_W'(sb));
		write_reg(REG_EXT_MARKER, PDATA_W'(mk));
		write_reg(REG_TWO_BYTE_EN, PDATA_W'(en));
	endtask

	// Sampled on the falling edge, when every update of the rising edge has
	// settled. Every item yields a result, so the short tail is only margin for
	// the two-stage result path.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || in_valid || accepted != results_seen);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_phase(logic [7:0] sb, logic [7:0] mk, logic en,
			int unsigned gm, int unsigned sm, int target);
		apply_setting(sb, mk, en);
		gap_max = gm;
		stall_max = sm;
		run_mix(target);
		wait_idle();
	endtask

	//----------------------------------------------------------------------
	// Test sequence
	//----------------------------------------------------------------------
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at the reset settings: start byte 0x1A, one-byte lengths.
		gap_max = 2;
		stall_max = 2;
		push_item(ACT_NOP, 8'hFF, 8'hFF);
		push_release();                 // nothing held yet
		push_recv(8'h03);               // length byte with no start byte before it
		push_recv(8'h00);
		push_recv(8'hFF);
		push_recv(8'h1A);               // doubled start byte completes the frame
		push_recv(8'h1A);
		push_read(8'h00);
		push_read(8'h02);
		push_recv(8'h26);               // dropped while the frame is held
		push_release();
		push_recv(8'h10);               // ignored in the complete phase
		push_recv(8'h1A);
		push_recv(8'h00);               // zero length goes to the error phase
		push_recv(8'hFF);               // ignored in the error phase
		push_recv(8'h1A);
		push_recv(8'hFF);               // largest one-byte length
		push_recv(8'h1A);
		push_recv(8'h1B);               // new frame opens before the old one ends
		push_recv(8'h1A);
		push_recv(8'h01);
		push_recv(8'h80);
		push_read(8'h00);
		push_read(8'h01);               // byte left behind by the first frame
		push_release();
		wait_idle();

		// Fill the whole store with one full-size frame so that every later read
		// hits an entry that has been written.
		apply_setting(START_BYTE_RST, EXT_MARKER_RST, 1'b1);
		push_release();
		send_frame(FRAME_BUFFER_DEPTH, FRAME_BUFFER_DEPTH);
		push_read(8'hFF);
		push_read(8'h00);
		push_release();
		force_pause = 1'b1;
		gap_max = 12;
		stall_max = 12;
		run_mix(50);
		wait_idle();

		// Register extremes, a marker equal to the start byte, and a mix of
		// idle patterns including stretches with none at all.
		run_phase(8'h00, 8'hFF, 1'b1, 12, 12, 85);
		run_phase(8'hFF, 8'h00, 1'b1, 0, 12, 85);
		run_phase(8'h5A, 8'h5A, 1'b1, 12, 0, 85);
		run_phase(8'hC8, 8'h64, 1'b0, 3, 3, 85);
		run_phase(START_BYTE_RST, EXT_MARKER_RST, 1'b0, 0, 0, 85);

		repeat (8) @(negedge clk);
		if (expected_results.size() != 0)
			report_mismatch("results never delivered", 0, expected_results.size());
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
